### rtl/core/bgm_pkg.sv
// ----------------------------------------------------------------------------
// bgm_pkg
// Shared constants and the exp2 coefficient table for the gamma mapper.
// ----------------------------------------------------------------------------
`default_nettype none

package bgm_pkg;

  // register indexes on the config channel
  localparam logic [1:0] REG_MAX_RAW   = 2'd0;
  localparam logic [1:0] REG_GAMMA_Q8  = 2'd1;
  localparam logic [1:0] REG_MIN_TENTH = 2'd2;

  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned GAMMA_W    = 11;
  localparam int unsigned MIN_W      = 10;
  localparam int unsigned LEVEL_W    = 8;

  localparam logic [GAMMA_W-1:0] GAMMA_LINEAR = 11'd256;
  localparam logic [GAMMA_W-1:0] GAMMA_RST    = 11'd256;

  // exp2 table: c_k = 2^-(2^-k) in Q1.30, k = 1..EXP_TBL_DEPTH
  localparam int unsigned EXP_TBL_DEPTH = 24;
  localparam int unsigned EXP_IDX_W     = 5;
  localparam int unsigned Q30_W         = 31;

  typedef logic [Q30_W-1:0] exp_tbl_t [1:EXP_TBL_DEPTH];

  function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
    logic [63:0] x;
    logic [63:0] res;
    logic [63:0] bitv;
    x    = x_in;
    res  = 64'd0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 64'd0) begin
      if (x >= res + bitv) begin
        x   = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic exp_tbl_t build_exp_tbl();
    exp_tbl_t    tbl;
    logic [63:0] c;
    c = 64'd1 << 29;
    for (int k = 1; k <= EXP_TBL_DEPTH; k++) begin
      c      = isqrt64(c << 30);
      tbl[k] = c[Q30_W-1:0];
    end
    return tbl;
  endfunction

  localparam exp_tbl_t EXP_TBL = build_exp_tbl();

endpackage

`default_nettype wire

### rtl/core/backlight_gamma_mapper_top.sv
// ----------------------------------------------------------------------------
// backlight_gamma_mapper_top
// Brightness level to gamma-corrected PWM duty, bit-serial arithmetic.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one brightness level per beat; m_axis returns one beat per
//   level: duty in tdata, write_needed and status in tuser. The cfg channel
//   writes max_raw, gamma_q8 and min_tenths_percent; it is always ready. The
//   user writes it only while the block is idle; the block does not enforce it.
// Steps: an unavailable or blank request goes straight to the output load.
//   Otherwise the level runs through a restoring divider by 255 (one
//   quotient bit per cycle), and, unless gamma is linear or the level is
//   full, a normalize loop, a squaring log2 loop (FRAC_BITS fraction bits),
//   one exponent multiply, an exp2 product loop (FRAC_BITS fraction bits)
//   and a right shift loop by the integer part; an integer part of 31 or
//   more skips the exp2 and shift loops and gives zero. Then scale, a second
//   divider pass by 1000 for the floor, a clamp and the output load. Both
//   divider passes run over a DVW-bit dividend;
//   DVW = max(FRAC_BITS+8, DUTY_WIDTH+11) = 27 with default parameters.
// One item at a time: s_axis_tready is high only while the sequencer idles;
//   a finished result may still wait in the output register meanwhile.
// Receiver stall: the result waits in the output register; the next item
//   finishes its work and then waits until the register frees.
// Reset: max_raw 0, gamma 1.0, floor 0, last duty 0, no beat pending.
// ----------------------------------------------------------------------------
`default_nettype none

module backlight_gamma_mapper_top
  import bgm_pkg::*;
#(
  parameter int unsigned DUTY_WIDTH = 16,
  parameter int unsigned FRAC_BITS  = 16,
  localparam int unsigned TDATA_W   = ((DUTY_WIDTH + 7) / 8) * 8
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // level in
  input  wire logic                  s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  input  wire logic [LEVEL_W-1:0]    s_axis_tdata_i,   // [7:0] level
  // duty out
  output logic                       m_axis_tvalid_o,
  input  wire logic                  m_axis_tready_i,
  output logic [TDATA_W-1:0]         m_axis_tdata_o,   // [DUTY_WIDTH-1:0] duty, rest 0
  output logic [1:0]                 m_axis_tuser_o,   // [0] write_needed, [1] status
  // config writes
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [1:0]            cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned DW   = DUTY_WIDTH;
  localparam int unsigned FB   = FRAC_BITS;
  localparam int unsigned DVW  = (FB + 8 > DW + 11) ? FB + 8 : DW + 11;
  localparam int unsigned CW   = $clog2(DVW + 1);
  localparam int unsigned SHW  = $clog2(FB + 1);
  localparam int unsigned NLW  = SHW + FB;
  localparam int unsigned TPW  = NLW + GAMMA_W + 1;   // nl*g + 128
  localparam int unsigned TW   = TPW - 8;
  localparam int unsigned IPW  = TW - FB;
  localparam int unsigned MW   = FB + 2;
  localparam int unsigned SPW  = FB + DW + 2;
  localparam int unsigned RMW  = 10;                 // remainder < 1000

  // sequencer states
  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_DIVF  = 4'd1;
  localparam logic [3:0] ST_NORM  = 4'd2;
  localparam logic [3:0] ST_LOG   = 4'd3;
  localparam logic [3:0] ST_TMUL  = 4'd4;
  localparam logic [3:0] ST_EXP   = 4'd5;
  localparam logic [3:0] ST_SHR   = 4'd6;
  localparam logic [3:0] ST_SCALE = 4'd7;
  localparam logic [3:0] ST_DIVL  = 4'd8;
  localparam logic [3:0] ST_CLAMP = 4'd9;
  localparam logic [3:0] ST_DONE  = 4'd10;

  // config registers
  logic [DW-1:0]      max_raw_q;
  logic [GAMMA_W-1:0] gamma_q;
  logic [MIN_W-1:0]   min_q;

  // control
  logic [3:0]    state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          ovalid_q, ovalid_d;
  logic [DW-1:0] last_q, last_d;

  // datapath (no reset)
  logic [DVW-1:0] dvd_q, dvd_d;        // dividend, shifts out MSB first
  logic [DVW-1:0] quo_q, quo_d;        // quotient, shifts in LSB
  logic [RMW-1:0] rem_q, rem_d;
  logic [MW-1:0]  m_q, m_d;            // log mantissa
  logic [SHW-1:0] sh_q, sh_d;          // normalize shift count
  logic [FB-1:0]  fb_q, fb_d;          // log fraction bits, then exp2 fraction
  logic [IPW-1:0] ip_q, ip_d;
  logic [Q30_W-1:0] r_q, r_d;
  logic [FB:0]    p_q, p_d;
  logic [DW:0]    duty_q, duty_d;
  logic           stat_q, stat_d;
  logic [DW-1:0]  odut_q, odut_d;
  logic           owr_q, owr_d;
  logic           ostat_q, ostat_d;

  // ------------------------------------------------------------------
  // Config port
  // ------------------------------------------------------------------
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_raw_q <= '0;
      gamma_q   <= GAMMA_RST;
      min_q     <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_MAX_RAW:   max_raw_q <= DW'(cfg_data_i);
        REG_GAMMA_Q8:  gamma_q   <= cfg_data_i[GAMMA_W-1:0];
        REG_MIN_TENTH: min_q     <= cfg_data_i[MIN_W-1:0];
        default:       ;
      endcase
    end
  end

  // ------------------------------------------------------------------
  // Bit-serial restoring divider, divisor 255 or 1000
  // ------------------------------------------------------------------
  logic [RMW:0]   rem_sh;
  logic [RMW:0]   divisor;
  logic           div_ge;
  logic [RMW-1:0] rem_nx;

  always_comb begin
    rem_sh  = {rem_q, dvd_q[DVW-1]};
    divisor = (state_q == ST_DIVF) ? 11'd255 : 11'd1000;
    div_ge  = (rem_sh >= divisor);
    rem_nx  = div_ge ? RMW'(rem_sh - divisor) : rem_sh[RMW-1:0];
  end

  // ------------------------------------------------------------------
  // Arithmetic of the individual steps
  // ------------------------------------------------------------------
  logic [2*MW-1:0]  sq;
  logic [MW-1:0]    msq;
  logic [NLW-1:0]   nl;
  logic [TPW-1:0]   tprod;
  logic [TW-1:0]    t_val;
  logic [2*Q30_W-1:0] eprod;
  logic [2*Q30_W:0] eprod_r;
  logic [Q30_W:0]   r_rnd;
  logic [SPW-1:0]   sprod;
  logic [DVW-1:0]   fl_num;
  logic [DW:0]      fl, d1;
  logic [FB:0]      frac;

  always_comb begin
    sq      = m_q * m_q;
    msq     = sq[FB +: MW];
    nl      = {sh_q, {FB{1'b0}}} - NLW'(fb_q);
    tprod   = TPW'(nl) * TPW'(gamma_q) + TPW'(128);
    t_val   = tprod[TPW-1:8];
    eprod   = r_q * EXP_TBL[cnt_q[EXP_IDX_W-1:0]];
    eprod_r = {1'b0, eprod} + (63'd1 << 29);
    r_rnd   = {1'b0, r_q} + (32'd1 << (29 - FB));
    sprod   = SPW'(p_q) * SPW'(max_raw_q) + (SPW'(1) << (FB - 1));
    fl_num  = DVW'(min_q) * DVW'(max_raw_q) + DVW'(500);
    frac    = quo_q[FB:0];
    fl      = quo_q[DW:0];
    d1      = (duty_q < fl) ? fl : duty_q;
  end

  // ------------------------------------------------------------------
  // Sequencer
  // ------------------------------------------------------------------
  logic in_fire, load_out;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign load_out        = (state_q == ST_DONE) && (!ovalid_q || m_axis_tready_i);

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    dvd_d    = dvd_q;
    quo_d    = quo_q;
    rem_d    = rem_q;
    m_d      = m_q;
    sh_d     = sh_q;
    fb_d     = fb_q;
    ip_d     = ip_q;
    r_d      = r_q;
    p_d      = p_q;
    duty_d   = duty_q;
    stat_d   = stat_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          stat_d = 1'b0;
          duty_d = '0;
          if (max_raw_q == '0) begin
            stat_d  = 1'b1;
            state_d = ST_DONE;
          end else if (s_axis_tdata_i == '0) begin
            state_d = ST_DONE;
          end else begin
            dvd_d   = DVW'({s_axis_tdata_i, {FB{1'b0}}}) + DVW'(127);
            rem_d   = '0;
            cnt_d   = CW'(DVW);
            state_d = ST_DIVF;
          end
        end
      end
      ST_DIVF, ST_DIVL: begin
        dvd_d = dvd_q << 1;
        rem_d = rem_nx;
        quo_d = {quo_q[DVW-2:0], div_ge};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          if (state_q == ST_DIVL) begin
            state_d = ST_CLAMP;
          end else begin
            state_d = ST_NORM;
          end
        end
      end
      ST_NORM: begin
        // first visit comes straight from the divider: pick up frac
        if (cnt_q == '0 && sh_q == '0 && m_q == '0) begin
          if (gamma_q == GAMMA_LINEAR || frac[FB]) begin
            p_d     = frac;
            state_d = ST_SCALE;
          end else begin
            m_d = MW'(frac);
          end
        end else if (m_q[FB]) begin
          cnt_d   = CW'(FB);
          fb_d    = '0;
          state_d = ST_LOG;
        end else begin
          m_d  = m_q << 1;
          sh_d = sh_q + 1'b1;
        end
      end
      ST_LOG: begin
        // square, renormalize, emit one fraction bit of log2
        if (msq[FB+1]) begin
          m_d  = msq >> 1;
          fb_d = {fb_q[FB-2:0], 1'b1};
        end else begin
          m_d  = msq;
          fb_d = {fb_q[FB-2:0], 1'b0};
        end
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == CW'(1)) state_d = ST_TMUL;
      end
      ST_TMUL: begin
        ip_d = t_val[TW-1:FB];
        fb_d = t_val[FB-1:0];
        if (t_val[TW-1:FB] >= IPW'(31)) begin
          p_d     = '0;
          state_d = ST_SCALE;
        end else begin
          r_d     = Q30_W'(1) << 30;
          cnt_d   = CW'(1);
          state_d = ST_EXP;
        end
      end
      ST_EXP: begin
        // one fraction bit of the exponent per cycle, MSB first
        if (fb_q[FB-1]) r_d = eprod_r[30 +: Q30_W];
        fb_d  = fb_q << 1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CW'(FB)) state_d = ST_SHR;
      end
      ST_SHR: begin
        if (ip_q == '0) begin
          p_d     = r_rnd[30-FB +: FB+1];
          state_d = ST_SCALE;
        end else begin
          r_d  = r_q >> 1;
          ip_d = ip_q - 1'b1;
        end
      end
      ST_SCALE: begin
        duty_d  = sprod[FB +: DW+1];
        dvd_d   = fl_num;
        rem_d   = '0;
        cnt_d   = CW'(DVW);
        state_d = ST_DIVL;
      end
      ST_CLAMP: begin
        if (d1 == '0) begin
          duty_d = (DW+1)'(1);
        end else if (d1 > (DW+1)'(max_raw_q)) begin
          duty_d = (DW+1)'(max_raw_q);
        end else begin
          duty_d = d1;
        end
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (load_out) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
    // clear the normalize markers on exit from the 255 divider pass so ST_NORM sees first entry
    if ((state_q == ST_DIVF) && (cnt_q == CW'(1))) begin
      m_d   = '0;
      sh_d  = '0;
      cnt_d = '0;
    end
  end

  // ------------------------------------------------------------------
  // Output register and last-duty tracking
  // ------------------------------------------------------------------
  always_comb begin
    ovalid_d = ovalid_q;
    last_d   = last_q;
    odut_d   = odut_q;
    owr_d    = owr_q;
    ostat_d  = ostat_q;
    if (m_axis_tvalid_o && m_axis_tready_i) ovalid_d = 1'b0;
    if (load_out) begin
      ovalid_d = 1'b1;
      odut_d   = duty_q[DW-1:0];
      ostat_d  = stat_q;
      owr_d    = !stat_q && (duty_q[DW-1:0] != last_q);
      if (!stat_q) last_d = duty_q[DW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      ovalid_q <= 1'b0;
      last_q   <= '0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      ovalid_q <= ovalid_d;
      last_q   <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q   <= dvd_d;
    quo_q   <= quo_d;
    rem_q   <= rem_d;
    m_q     <= m_d;
    sh_q    <= sh_d;
    fb_q    <= fb_d;
    ip_q    <= ip_d;
    r_q     <= r_d;
    p_q     <= p_d;
    duty_q  <= duty_d;
    stat_q  <= stat_d;
    odut_q  <= odut_d;
    owr_q   <= owr_d;
    ostat_q <= ostat_d;
  end

  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tdata_o  = TDATA_W'(odut_q);
  assign m_axis_tuser_o  = {ostat_q, owr_q};

`ifndef SYNTHESIS
  a_unavail_blank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && ostat_q) |-> (odut_q == '0 && !owr_q))
    else $error("unavailable beat carries duty or write flag");

  a_duty_le_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && !ostat_q) |-> (odut_q <= max_raw_q))
    else $error("duty above max_raw");

  a_last_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && !ostat_q) |-> (last_q == odut_q))
    else $error("last duty not updated with reported duty");

  a_log_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOG || state_q == ST_DIVF || state_q == ST_DIVL) |-> (cnt_q != '0))
    else $error("loop counter ran out inside a loop state");
`endif

endmodule

`default_nettype wire

### dv/backlight_gamma_mapper_top_tb.sv
// ----------------------------------------------------------------------------
// backlight_gamma_mapper_top_tb
// Self-checking bench: brightness beats in, duty beats checked against an
// in-bench fixed-point model of the gamma curve, floor, clamp and write flag.
// ----------------------------------------------------------------------------
`default_nettype none

module backlight_gamma_mapper_top_tb;
  import bgm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FB       = 16;        // fraction bits of the DUT
  localparam int unsigned DW       = 16;        // duty width of the DUT
  localparam int unsigned IDLE_CAP = 4000;      // cycles with no beat at all
  localparam int unsigned DRAIN    = 200;       // worst item latency, rounded up

  typedef struct packed {
    logic [DW-1:0] duty;
    logic          write_needed;
    logic          status;
  } duty_beat_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [LEVEL_W-1:0]    s_axis_tdata_i = '0;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [15:0]           m_axis_tdata_o;
  logic [1:0]            m_axis_tuser_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [1:0]            cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  backlight_gamma_mapper_top u_top (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i, .s_axis_tready_o, .s_axis_tdata_i,
    .m_axis_tvalid_o, .m_axis_tready_i, .m_axis_tdata_o, .m_axis_tuser_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Shadow of the block: registers, last reported duty, exp2 coefficients
  // --------------------------------------------------------------------------
  logic [15:0] sh_max_raw;
  logic [10:0] sh_gamma;
  logic [9:0]  sh_min_tenths;
  logic [15:0] sh_last_duty;
  logic [63:0] exp_coef [1:FB];

  duty_beat_t  pending_duty_q [$];
  int unsigned err_count = 0;
  bit          no_idle = 1'b0;   // burst stretches: neither side idles
  int unsigned rx_hold = 0;      // one long receiver hold-off when set
  int unsigned idle_cycles = 0;

  // bit-by-bit integer square root, root below 2^32
  function automatic logic [63:0] root_floor(input logic [63:0] x);
    logic [63:0] r;
    logic [63:0] trial;
    r = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = r | (64'd1 << b);
      if (trial * trial <= x) r = trial;
    end
    return r;
  endfunction

  // frac^gamma through log2 by squaring, then exp2 by the coefficient product
  function automatic logic [63:0] gamma_pow(input logic [63:0] frac, input logic [63:0] g);
    int          e;
    logic [63:0] m, fbits, nl, t, ip, f, r;
    e     = FB - 1;
    fbits = '0;
    while (e > 0 && frac[e] == 1'b0) e--;
    m = frac << (FB - e);
    for (int i = 1; i <= FB; i++) begin
      m = (m * m) >> FB;
      if (m >= (64'd2 << FB)) begin
        m = m >> 1;
        fbits[FB-i] = 1'b1;
      end
    end
    nl = (64'(FB - e) << FB) - fbits;
    t  = (nl * g + 64'd128) >> 8;
    ip = t >> FB;
    f  = t & ((64'd1 << FB) - 1);
    if (ip >= 31) return '0;
    r = 64'd1 << 30;
    for (int i = 1; i <= FB; i++)
      if (f[FB-i]) r = (r * exp_coef[i] + (64'd1 << 29)) >> 30;
    r = r >> ip;
    return (r + (64'd1 << (29 - FB))) >> (30 - FB);
  endfunction

  // expected beat for one level; advances the last-duty shadow unless unavailable
  function automatic duty_beat_t map_level(input logic [7:0] level);
    duty_beat_t  o;
    logic [63:0] frac, p, d, fl;
    o = '0;
    if (sh_max_raw == 0) begin
      o.status = 1'b1;
      return o;
    end
    if (level == 0) begin
      d = '0;
    end else begin
      frac = ((64'(level) << FB) + 64'd127) / 64'd255;
      if (sh_gamma == GAMMA_LINEAR || frac >= (64'd1 << FB)) p = frac;
      else p = gamma_pow(frac, 64'(sh_gamma));
      d  = (p * sh_max_raw + (64'd1 << (FB - 1))) >> FB;
      fl = (64'(sh_min_tenths) * sh_max_raw + 64'd500) / 64'd1000;
      if (d < fl) d = fl;
      if (d < 1) d = 1;
      if (d > sh_max_raw) d = sh_max_raw;
    end
    o.duty         = d[DW-1:0];
    o.write_needed = (d[DW-1:0] != sh_last_duty);
    sh_last_duty   = d[DW-1:0];
    return o;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
    err_count++;
  endtask

  // --------------------------------------------------------------------------
  // Sender side. Valid is only lowered when a gap follows, so a back-to-back
  // beat never sees a low and a high NBA in the same step.
  // --------------------------------------------------------------------------
  task automatic send_level(input logic [7:0] level);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= level;
    // tready comes from a register, so it is settled at the falling edge
    do @(negedge clk_i); while (!s_axis_tready_o);
    @(posedge clk_i);
    pending_duty_q.push_back(map_level(level));
  endtask

  task automatic quiesce();
    s_axis_tvalid_i <= 1'b0;
    wait (pending_duty_q.size() == 0);
    // blank and unavailable requests finish early; let any tail settle
    repeat (DRAIN) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(negedge clk_i); while (!cfg_ready_o);
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_MAX_RAW:   sh_max_raw    = value;
      REG_GAMMA_Q8:  sh_gamma      = value[10:0];
      REG_MIN_TENTH: sh_min_tenths = value[9:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic set_curve(input logic [15:0] mx, input logic [15:0] g,
                           input logic [15:0] mn);
    write_reg(REG_MAX_RAW, mx);
    write_reg(REG_GAMMA_Q8, g);
    write_reg(REG_MIN_TENTH, mn);
  endtask

  // --------------------------------------------------------------------------
  // Receiver side and result check
  // --------------------------------------------------------------------------
  initial begin : duty_sink
    int unsigned wait_n;
    duty_beat_t  got, want;
    @(posedge rst_ni);
    forever begin
      if (rx_hold > 0) begin
        wait_n  = rx_hold;
        rx_hold = 0;
      end else begin
        wait_n = no_idle ? 0 : $urandom_range(0, 6);
      end
      if (wait_n > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (wait_n) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do @(negedge clk_i); while (!m_axis_tvalid_o);
      got.duty         = m_axis_tdata_o[DW-1:0];
      got.write_needed = m_axis_tuser_o[0];
      got.status       = m_axis_tuser_o[1];
      @(posedge clk_i);
      if (pending_duty_q.size() == 0) begin
        report_mismatch("unexpected duty beat", got.duty, 0);
      end else begin
        want = pending_duty_q.pop_front();
        if (got.duty !== want.duty) report_mismatch("duty", got.duty, want.duty);
        if (got.write_needed !== want.write_needed)
          report_mismatch("write_needed", got.write_needed, want.write_needed);
        if (got.status !== want.status) report_mismatch("status", got.status, want.status);
      end
    end
  end

  // watchdog: any beat on any channel resets the idle count
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_CAP) begin
        $display("backlight_gamma_mapper_top regression: fail");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // reset state has max_raw 0: every level reports unavailable
  task automatic test_unavailable();
    send_level(8'd0);
    send_level(8'd255);
    send_level(8'd77);
    quiesce();
  endtask

  // field extremes, linear bypass, full level, out-of-range gamma and floor
  task automatic test_directed();
    set_curve(16'hFFFF, 16'd256, 16'd0);
    send_level(8'd255);
    send_level(8'd255);            // same duty again: no write
    send_level(8'd1);
    send_level(8'd0);              // blank still tracks last duty
    send_level(8'd128);
    quiesce();
    set_curve(16'd1000, 16'd26, 16'd0);
    send_level(8'd1);
    send_level(8'd254);
    send_level(8'd255);
    quiesce();
    set_curve(16'd65535, 16'd1280, 16'd0);
    send_level(8'd1);              // deep curve: rounds to zero, lifted to 1
    send_level(8'd127);
    send_level(8'd255);
    quiesce();
    set_curve(16'd500, 16'd0, 16'd1000);  // gamma 0 gives full duty
    send_level(8'd3);
    quiesce();
    set_curve(16'd1, 16'h07FF, 16'd1023); // floor setting above 100 percent, rounds to max_raw
    send_level(8'd1);
    send_level(8'd200);
    send_level(8'd0);
    quiesce();
    set_curve(16'd0, 16'd512, 16'd10);    // back to unavailable
    send_level(8'd99);
    quiesce();
  endtask

  // receiver holds off while beats keep coming: input must stall
  task automatic test_backpressure();
    set_curve(16'd4095, 16'd563, 16'd5);
    no_idle = 1'b1;
    rx_hold = 400;
    repeat (12) send_level(8'($urandom_range(0, 255)));
    no_idle = 1'b0;
    quiesce();
  endtask

  // random settings per phase, extremes mixed in, random levels
  task automatic test_random_curves();
    logic [15:0] mx, g, mn;
    int unsigned pick;
    for (int ph = 0; ph < 19; ph++) begin
      pick = $urandom_range(0, 9);
      mx = (pick == 0) ? 16'd0 : (pick == 1) ? 16'hFFFF : (pick == 2) ? 16'd1 :
           16'($urandom());
      pick = $urandom_range(0, 9);
      g  = (pick == 0) ? 16'd26 : (pick == 1) ? 16'd1280 : (pick == 2) ? 16'd256 :
           (pick == 3) ? 16'($urandom()) : 16'($urandom_range(26, 1280));
      pick = $urandom_range(0, 9);
      mn = (pick == 0) ? 16'd0 : (pick == 1) ? 16'd1000 : (pick == 2) ? 16'($urandom()) :
           16'($urandom_range(0, 1000));
      set_curve(mx, g, mn);
      no_idle = (ph % 4 == 3);
      for (int i = 0; i < 100; i++)
        send_level((i % 10 == 0) ? 8'($urandom_range(0, 1) * 255) : 8'($urandom()));
      no_idle = 1'b0;
      quiesce();
    end
  endtask

  initial begin : run
    logic [63:0] c;
    c = 64'd1 << 29;
    for (int k = 1; k <= FB; k++) begin
      c = root_floor(c << 30);
      exp_coef[k] = c;
    end
    sh_max_raw    = '0;
    sh_gamma      = GAMMA_RST;
    sh_min_tenths = '0;
    sh_last_duty  = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_unavailable();
    test_directed();
    test_backpressure();
    test_random_curves();
    quiesce();
    if (err_count == 0) begin
      $display("backlight_gamma_mapper_top regression: pass");
    end else begin
      $display("backlight_gamma_mapper_top regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
